>>> src/gpg_pkg.sv
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared types and constants of the polar Gaussian generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

    localparam int UNIFORM_W  = 16;
    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 16;   // sample fraction bits
    localparam int M_W        = 29;   // normalized W, Q1.28
    localparam int K_W        = 5;    // exponent of W
    localparam int LOG_STEPS  = 28;
    localparam int DIV_STEPS  = 35;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic [CFG_IDX_W-1:0] CFG_MEAN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STD_DEV = 2'd1;

    localparam logic [SAMPLE_W-1:0] MEAN_RESET    = 24'd0;
    localparam logic [SAMPLE_W-1:0] STD_DEV_RESET = 24'd65536;

    typedef struct packed {
        logic signed [UNIFORM_W-1:0] uniform_a;
        logic signed [UNIFORM_W-1:0] uniform_b;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_out;

    // accepted pair with W already normalized as m * 2^-k
    typedef struct packed {
        logic signed [UNIFORM_W-1:0] u1;
        logic signed [UNIFORM_W-1:0] u2;
        logic [M_W-1:0]              m;
        logic [K_W-1:0]              k;
    } t_job;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [SAMPLE_W-1:0]  data;
        logic                 wr;
    } t_cfg_wr;

endpackage

>>> src/gpg_front.sv
// ----------------------------------------------------------------------------
// gpg_front
// Registers the uniform pair, forms W, drops rejected pairs and normalizes W.
// ----------------------------------------------------------------------------
module gpg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  gpg_pkg::t_in  i_item,
    output logic          o_full,
    output logic          o_push,
    output gpg_pkg::t_job o_job
);

    logic         r_fv;
    gpg_pkg::t_in r_in;

    logic [16:0] a1, a2;
    logic [31:0] w;
    logic [4:0]  p;
    logic        reject;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= i_take;
        end
        if (i_take) begin
            r_in <= i_item;
        end
    end

    always_comb begin
        a1 = r_in.uniform_a[15] ? (17'd0 - {1'b1, r_in.uniform_a}) : {1'b0, r_in.uniform_a};
        a2 = r_in.uniform_b[15] ? (17'd0 - {1'b1, r_in.uniform_b}) : {1'b0, r_in.uniform_b};
        w  = ({15'd0, a1} * {15'd0, a1}) + ({15'd0, a2} * {15'd0, a2});
        reject = (w == 32'd0) || (w[31:30] != 2'b00);
        // msb position of W
        p = 5'd0;
        for (int i = 0; i < 30; i++) begin
            if (w[i]) begin
                p = 5'(i);
            end
        end
        o_job.u1 = r_in.uniform_a;
        o_job.u2 = r_in.uniform_b;
        o_job.k  = 5'd30 - p;
        if (p == 5'd29) begin
            o_job.m = w[29:1];
        end else begin
            o_job.m = 29'(w[28:0] << (5'd28 - p));
        end
    end

    assign o_push = r_fv && !reject;
    assign o_full = r_fv;

endmodule

>>> src/gpg_fifo.sv
// ----------------------------------------------------------------------------
// gpg_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module gpg_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  gpg_pkg::t_job                    i_job,
    input  logic                             i_pop,
    output gpg_pkg::t_job                    o_head,
    output logic                             o_empty,
    output logic [gpg_pkg::FIFO_AW:0]        o_count
);

    gpg_pkg::t_job                r_mem [gpg_pkg::FIFO_DEPTH];
    logic [gpg_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [gpg_pkg::FIFO_AW:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (gpg_pkg::FIFO_AW+1)'(i_push) - (gpg_pkg::FIFO_AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

>>> src/gpg_back.sv
// ----------------------------------------------------------------------------
// gpg_back
// Computes sqrt(-2 ln W / W) by iteration and scales both samples.
// ----------------------------------------------------------------------------
module gpg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gpg_pkg::t_cfg_wr i_cfg,
    input  logic             i_avail,
    input  gpg_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_valid,
    output gpg_pkg::t_out    o_result
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOG   = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_SQRT  = 7'b0010000,
        S_OUT1  = 7'b0100000,
        S_OUT2  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [gpg_pkg::SAMPLE_W-1:0] r_mean, r_std;
    logic [gpg_pkg::CNT_W-1:0]    r_cnt;
    logic signed [15:0]           r_u1, r_u2;
    logic [28:0]                  r_m, r_lm;
    logic [4:0]                   r_k;
    logic [27:0]                  r_y;
    logic [3:0]                   r_h;
    logic [34:0]                  r_nb;
    logic [33:0]                  r_q;
    logic [28:0]                  r_rem;
    logic [63:0]                  r_x;
    logic [31:0]                  r_root;
    logic [34:0]                  r_srem;

    // output pipeline
    logic        r_av, r_bv, r_cv, r_ov;
    logic [47:0] r_prod;
    logic [3:0]  r_ah;
    logic        r_aneg, r_bneg, r_cneg;
    logic        r_alast, r_blast, r_clast;
    logic [23:0] r_xs;
    logic [31:0] r_dev;
    gpg_pkg::t_out r_res;

    logic [57:0] sq;
    logic [32:0] lval;
    logic [62:0] gfull;
    logic [33:0] g34;
    logic [29:0] dt;
    logic [34:0] st, trial;
    logic        last_step;
    logic signed [15:0] iu;
    logic [15:0] imag;
    logic [4:0]  sh;
    logic [48:0] xr;
    logic [47:0] dprod;
    logic signed [33:0] v;

    assign o_pop = (r_state == S_IDLE) && i_avail;

    always_comb begin
        sq    = r_lm * r_lm;
        lval  = {r_k, 28'd0} - {5'd0, r_y};
        gfull = (63'(lval) * 63'(gpg_pkg::LN2_Q30)) + 63'(64'd1 << 28);
        g34   = gfull[62:29];
        dt    = {r_rem, r_nb[34]};
        st    = {r_srem[32:0], r_x[63:62]};
        trial = {1'b0, r_root, 2'b01};
        iu    = (r_state == S_OUT1) ? r_u1 : r_u2;
        imag  = iu[15] ? (16'd0 - iu) : iu;
        last_step = 1'b0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_avail) n_state = S_LOG;
            S_LOG:   begin
                last_step = (r_cnt == 6'(gpg_pkg::LOG_STEPS - 1));
                if (last_step) n_state = S_SCALE;
            end
            S_SCALE: n_state = S_DIV;
            S_DIV:   begin
                last_step = (r_cnt == 6'(gpg_pkg::DIV_STEPS - 1));
                if (last_step) n_state = S_SQRT;
            end
            S_SQRT:  begin
                last_step = (r_cnt == 6'(gpg_pkg::SQRT_STEPS - 1));
                if (last_step) n_state = S_OUT1;
            end
            S_OUT1:  n_state = S_OUT2;
            S_OUT2:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mean  <= gpg_pkg::MEAN_RESET;
            r_std   <= gpg_pkg::STD_DEV_RESET;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.wr && i_cfg.index == gpg_pkg::CFG_MEAN) begin
                r_mean <= i_cfg.data;
            end
            if (i_cfg.wr && i_cfg.index == gpg_pkg::CFG_STD_DEV) begin
                r_std <= i_cfg.data;
            end
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                r_u1 <= i_job.u1;
                r_u2 <= i_job.u2;
                r_m  <= i_job.m;
                r_lm <= i_job.m;
                r_k  <= i_job.k;
                r_y  <= '0;
            end
            S_LOG: begin
                // square and compare, one fraction bit of log2(m) a step
                if (sq[57]) begin
                    r_lm <= sq[57:29];
                    r_y  <= {r_y[26:0], 1'b1};
                end else begin
                    r_lm <= sq[56:28];
                    r_y  <= {r_y[26:0], 1'b0};
                end
            end
            S_SCALE: begin
                r_h <= r_k[4:1];
                if (r_k[0]) begin
                    r_rem <= {1'b0, g34[33:6]};
                    r_nb  <= {g34[5:0], 1'b0, 28'd0};
                end else begin
                    r_rem <= {2'b00, g34[33:7]};
                    r_nb  <= {g34[6:0], 28'd0};
                end
            end
            S_DIV: begin
                r_nb <= {r_nb[33:0], 1'b0};
                if (dt >= {1'b0, r_m}) begin
                    r_rem <= 29'(dt - {1'b0, r_m});
                    r_q   <= {r_q[32:0], 1'b1};
                end else begin
                    r_rem <= dt[28:0];
                    r_q   <= {r_q[32:0], 1'b0};
                end
                if (last_step) begin
                    r_root <= '0;
                    r_srem <= '0;
                    if (dt >= {1'b0, r_m}) begin
                        r_x <= {1'b0, r_q, 1'b1, 28'd0};
                    end else begin
                        r_x <= {1'b0, r_q, 1'b0, 28'd0};
                    end
                end
            end
            S_SQRT: begin
                r_x <= {r_x[61:0], 2'b00};
                if (st >= trial) begin
                    r_srem <= st - trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_srem <= st;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            S_OUT1, S_OUT2: begin
            end
            default: begin
            end
        endcase
    end

    function automatic logic signed [33:0] r_bneg_dev_sel();
        logic signed [33:0] mx;
        logic signed [33:0] dx;
        mx = 34'(signed'(r_mean));
        dx = signed'({2'b00, r_dev});
        return r_cneg ? (mx - dx) : (mx + dx);
    endfunction

    // sample pipeline: U*s, round to X, std_dev*X, add mean and saturate
    always_comb begin
        sh    = 5'd27 - {1'b0, r_ah};
        xr    = ({1'b0, r_prod} + (49'd1 << (sh - 5'd1))) >> sh;
        dprod = 48'(r_xs) * 48'(r_std);
        v     = r_bneg_dev_sel();
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_av <= (r_state == S_OUT1) || (r_state == S_OUT2);
            r_bv <= r_av;
            r_cv <= r_bv;
            r_ov <= r_cv;
        end
        r_prod  <= 48'(imag) * 48'(r_root);
        r_ah    <= r_h;
        r_aneg  <= iu[15];
        r_alast <= (r_state == S_OUT2);

        r_xs    <= xr[23:0];
        r_bneg  <= r_aneg;
        r_blast <= r_alast;

        r_dev   <= 32'((dprod + 48'd32768) >> gpg_pkg::FRAC_W);
        r_cneg  <= r_bneg;
        r_clast <= r_blast;

        r_res.last <= r_clast;
        if (v > 34'sd8388607) begin
            r_res.sample <= 24'sh7FFFFF;
        end else if (v < -34'sd8388608) begin
            r_res.sample <= 24'sh800000;
        end else begin
            r_res.sample <= v[23:0];
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

endmodule

>>> src/gaussian_polar_generator_unit.sv
// ----------------------------------------------------------------------------
// gaussian_polar_generator_unit
// Polar-method Gaussian sample generator, two samples per accepted pair.
// ----------------------------------------------------------------------------
// Output: the first sample of a pair is strobed through the output pipeline, the
// second in the cycle after; the receiver cannot stall, samples are never held.
// The back end takes one pair at a time: a pop, 28 log2 steps, a scale, 35 divide
// steps, 32 square-root steps and the two issue states. Pairs are taken
// back to back until the front register plus 4-entry queue hold 4; rejected pairs
// drop in the front. Sync active-low reset clears control, mean 0, std_dev 1.0.
module gaussian_polar_generator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  gpg_pkg::t_in                        i_item,
    output logic                                o_valid,
    output gpg_pkg::t_out                       o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gpg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gpg_pkg::SAMPLE_W-1:0]        i_cfg_data
);

    logic                       take, front_full, push, pop, empty;
    gpg_pkg::t_job              job_in, job_head;
    logic [gpg_pkg::FIFO_AW:0]  count;
    gpg_pkg::t_cfg_wr           cfg;

    assign o_cfg_ready = 1'b1;
    assign cfg.wr      = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    // keep room for the item sitting in the front register
    assign o_busy = ((count + (gpg_pkg::FIFO_AW+1)'(front_full))
                     >= (gpg_pkg::FIFO_AW+1)'(gpg_pkg::FIFO_DEPTH));
    assign take   = i_start && !o_busy;

    gpg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_item),
        .o_full  (front_full),
        .o_push  (push),
        .o_job   (job_in)
    );

    gpg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_empty (empty),
        .o_count (count)
    );

    gpg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_avail  (!empty),
        .i_job    (job_head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

>>> dv/gaussian_polar_generator_unit_test.sv
// ----------------------------------------------------------------------------
// gaussian_polar_generator_unit_test
// Self-checking bench for the polar Gaussian generator. Uniform pairs are
// sent through the start/busy handshake. Each pair's samples are predicted in
// fixed point, and every strobed result is checked in order. Mean and std_dev
// are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module gaussian_polar_generator_unit_test;

    localparam int        U_W        = gpg_pkg::UNIFORM_W;
    localparam int        S_W        = gpg_pkg::SAMPLE_W;
    localparam int        IDX_W      = gpg_pkg::CFG_IDX_W;
    localparam int        INT_FRAC   = 28;
    localparam int        W_FRAC     = 2 * (U_W - 1);
    localparam int        DRAIN_CYC  = 150;
    localparam int        IN_CIRCLE  = 23170;   // |a|,|b| <= this keeps W < 1
    localparam longint    SAMPLE_MAX = 64'sd8388607;
    localparam longint    SAMPLE_MIN = -64'sd8388608;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    gpg_pkg::t_in         i_item;
    logic                 o_valid;
    gpg_pkg::t_out        o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index;
    logic [S_W-1:0]       i_cfg_data;

    gaussian_polar_generator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of the registers
    longint            mean_val;
    longint unsigned   std_dev_val;

    gpg_pkg::t_out expected_samples[$];
    int   errors;
    int   pairs_sent;
    int   pairs_rejected;
    int   samples_checked;
    int   cfg_writes;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // fractional log2 of m in [1,2), Q.28, by repeated squaring
    function automatic longint unsigned log2_fraction(input longint unsigned m);
        longint unsigned y;
        y = 0;
        for (int i = 1; i <= INT_FRAC; i++) begin
            m = (m * m) >> INT_FRAC;
            if (m >= (64'd2 << INT_FRAC)) begin
                m = m >> 1;
                y = y | (64'd1 << (INT_FRAC - i));
            end
        end
        return y;
    endfunction

    function automatic logic [S_W-1:0] scaled_sample(input longint u,
                                                     input longint unsigned s,
                                                     input int h);
        longint unsigned mag;
        longint unsigned x;
        longint unsigned dev;
        longint          v;
        int              sh;
        mag = (u < 0) ? longint'(-u) : longint'(u);
        sh  = U_W - 1 + INT_FRAC - h - gpg_pkg::FRAC_W;
        x   = (mag * s + (64'd1 << (sh - 1))) >> sh;
        dev = (x * std_dev_val + (64'd1 << (gpg_pkg::FRAC_W - 1))) >> gpg_pkg::FRAC_W;
        v   = (u < 0) ? mean_val - longint'(dev) : mean_val + longint'(dev);
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return v[S_W-1:0];
    endfunction

    // pushes the samples a pair produces; returns 0 when the pair is rejected
    function automatic bit predict_pair(input gpg_pkg::t_in item);
        longint          u1;
        longint          u2;
        longint unsigned w;
        longint unsigned m;
        longint unsigned l;
        longint unsigned g;
        longint unsigned q;
        longint unsigned s;
        int              p;
        int              k;
        int              h;
        gpg_pkg::t_out   r;
        u1 = item.uniform_a;
        u2 = item.uniform_b;
        w  = longint'(u1 * u1) + longint'(u2 * u2);
        if (w == 0 || w >= (64'd1 << W_FRAC)) return 1'b0;
        p = 63;
        while (w[p] == 1'b0) p--;
        k = W_FRAC - p;
        m = (p > INT_FRAC) ? (w >> (p - INT_FRAC)) : (w << (INT_FRAC - p));
        l = (longint'(k) << INT_FRAC) - log2_fraction(m);
        g = (l * longint'(gpg_pkg::LN2_Q30) + (64'd1 << 28)) >> 29;
        if (k % 2 == 1) begin
            g = g << 1;
            h = (k - 1) / 2;
        end else begin
            h = k / 2;
        end
        q = (g << INT_FRAC) / m;
        s = int_sqrt(q << INT_FRAC);
        r.sample = scaled_sample(u1, s, h);
        r.last   = 1'b0;
        expected_samples.push_back(r);
        r.sample = scaled_sample(u2, s, h);
        r.last   = 1'b1;
        expected_samples.push_back(r);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected sample %h last %b", $time,
                         o_result.sample, o_result.last);
            end else begin
                gpg_pkg::t_out exp_r;
                exp_r = expected_samples.pop_front();
                samples_checked++;
                if (o_result.sample !== exp_r.sample) begin
                    errors++;
                    $display("%0t: sample expected %h actual %h", $time,
                             exp_r.sample, o_result.sample);
                end
                if (o_result.last !== exp_r.last) begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time,
                             exp_r.last, o_result.last);
                end
            end
        end
    end

    // start is left high after a transfer so back-to-back pairs need no gap
    task automatic send_pair(input logic [U_W-1:0] a,
                             input logic [U_W-1:0] b, input int gap);
        gpg_pkg::t_in item;
        item.uniform_a = a;
        item.uniform_b = b;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_busy);
        pairs_sent++;
        if (!predict_pair(item)) pairs_rejected++;
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [S_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
        if (idx == gpg_pkg::CFG_MEAN) mean_val = longint'($signed(data));
        else if (idx == gpg_pkg::CFG_STD_DEV) std_dev_val = data;
    endtask

    task automatic set_config(input logic [S_W-1:0] mean_w,
                              input logic [S_W-1:0] std_w);
        wait_idle();
        write_reg(gpg_pkg::CFG_MEAN, mean_w);
        write_reg(gpg_pkg::CFG_STD_DEV, std_w);
    endtask

    task automatic run_directed_set();
        send_pair(16'sd0, 16'sd0, 0);            // W zero
        send_pair(-16'sd32768, -16'sd32768, 1);  // W far above one
        send_pair(-16'sd32768, 16'sd0, 0);       // W exactly one
        send_pair(16'sd32767, 16'sd1, 2);        // just below one
        send_pair(16'sd32767, 16'sd0, 0);        // just below one
        send_pair(16'sd0, -16'sd32767, 0);
        send_pair(16'sd1, 16'sd0, 3);            // smallest W
        send_pair(16'sd0, -16'sd1, 0);
        send_pair(-16'sd1, -16'sd1, 0);
        send_pair(16'sd23170, -16'sd23170, 4);
        send_pair(16'sd16384, 16'sd16384, 0);
        send_pair(-16'sd12345, 16'sd321, 1);
    endtask

    task automatic test_reset_defaults();
        run_directed_set();
    endtask

    // saturation at both ends and zero scale
    task automatic test_config_extremes();
        set_config(24'h7FFFFF, 24'hFFFFFF);
        run_directed_set();
        set_config(24'h800000, 24'hFFFFFF);
        run_directed_set();
        set_config(24'h123456, 24'h000000);
        send_pair(16'sd1000, -16'sd2000, 0);
        send_pair(16'sd1, 16'sd1, 0);
        // index beyond the register list must be ignored
        wait_idle();
        write_reg(IDX_W'(2), 24'($urandom));
        write_reg(IDX_W'(3), 24'($urandom));
        send_pair(16'sd5000, 16'sd7000, 0);
    endtask

    task automatic test_random_pairs(input int count);
        logic [U_W-1:0] a;
        logic [U_W-1:0] b;
        int             mode;
        int             gap;
        bit             burst;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 9);
            if (mode <= 6) begin
                a = U_W'($signed($urandom_range(0, 2 * IN_CIRCLE)) - IN_CIRCLE);
                b = U_W'($signed($urandom_range(0, 2 * IN_CIRCLE)) - IN_CIRCLE);
            end else if (mode == 7) begin
                a = U_W'($signed($urandom_range(0, 128)) - 64);
                b = U_W'($signed($urandom_range(0, 128)) - 64);
            end else begin
                a = U_W'($urandom);
                b = U_W'($urandom);
            end
            if (n % 64 == 0) burst = ($urandom_range(0, 2) == 0);
            gap = burst ? 0 : $urandom_range(0, 4);
            send_pair(a, b, gap);
        end
    endtask

    // sender holds off until the unit has drained, then resumes
    task automatic test_drain_pause();
        test_random_pairs(20);
        wait_idle();
        test_random_pairs(20);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_item         = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        errors         = 0;
        pairs_sent     = 0;
        pairs_rejected = 0;
        samples_checked = 0;
        cfg_writes     = 0;
        mean_val       = 0;
        std_dev_val    = 64'd65536;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_drain_pause();
        for (int ph = 0; ph < 4; ph++) begin
            set_config(24'($urandom), 24'($urandom_range(0, 24'h0FFFFF)));
            test_random_pairs(210);
        end
        set_config(24'h000000, 24'h010000);
        test_random_pairs(40);

        wait_idle();
        $display("covered %0d pairs (%0d rejected), %0d samples checked, %0d register writes",
                 pairs_sent, pairs_rejected, samples_checked, cfg_writes);
        if (errors == 0) begin
            $display("gaussian_polar_generator_unit_test passed");
        end else begin
            $display("gaussian_polar_generator_unit_test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d samples outstanding", expected_samples.size());
        $display("gaussian_polar_generator_unit_test failed");
        $finish;
    end

endmodule
